// ===== rtl/iuv_pkg.sv =====
// Shared types, constants and helper functions for the IPv4/UDP receive validator.
// Depends on nothing; imported by ipv4_udp_receive_validator and the testbench.
`default_nettype none

package iuv_pkg;

	// Bytes beyond this position in a frame are ignored.
	localparam int MAX_FRAME_BYTES = 1024;
	// The byte counter saturates at MAX_FRAME_BYTES, so it must hold that value.
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	localparam logic [15:0] CLIENT_PORT_RESET = 16'd68;
	localparam logic [15:0] SUM_VALID         = 16'hffff;
	localparam logic [7:0]  PROTO_UDP         = 8'd17;
	localparam logic [3:0]  IP_VERSION_4      = 4'd4;
	localparam logic [3:0]  IHL_NO_OPTIONS    = 4'd5;
	localparam logic [15:0] IP_HDR_BYTES      = 16'd20;
	localparam logic [15:0] IP_UDP_HDR_BYTES  = 16'd28;

	// Byte positions within the datagram.
	localparam logic [CNT_W-1:0] POS_VER_IHL   = CNT_W'(0);
	localparam logic [CNT_W-1:0] POS_TLEN_HI   = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_TLEN_LO   = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_PROTO     = CNT_W'(9);
	localparam logic [CNT_W-1:0] POS_PSEUDO    = CNT_W'(12);
	localparam logic [CNT_W-1:0] POS_IP_END    = CNT_W'(20);
	localparam logic [CNT_W-1:0] POS_DPORT_HI  = CNT_W'(22);
	localparam logic [CNT_W-1:0] POS_DPORT_LO  = CNT_W'(23);
	localparam logic [CNT_W-1:0] POS_ULEN_HI   = CNT_W'(24);
	localparam logic [CNT_W-1:0] POS_ULEN_LO   = CNT_W'(25);
	localparam logic [CNT_W-1:0] POS_UCHK_HI   = CNT_W'(26);
	localparam logic [CNT_W-1:0] POS_UCHK_LO   = CNT_W'(27);
	localparam logic [CNT_W-1:0] POS_ALWAYS    = CNT_W'(4);

	typedef enum logic [2:0] {
		ST_ACCEPT   = 3'd0,
		ST_NOT_UDP  = 3'd1,
		ST_BAD_VER  = 3'd2,
		ST_BAD_IHL  = 3'd3,
		ST_BAD_IPSUM = 3'd4,
		ST_BAD_PORT = 3'd5,
		ST_BAD_ULEN = 3'd6,
		ST_BAD_USUM = 3'd7
	} status_t;

	// Ones-complement addition with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// Places a byte in the high half (even position) or low half (odd position).
	function automatic logic [15:0] put_half(input logic [15:0] field, input logic odd,
			input logic [7:0] b);
		return odd ? {field[15:8], b} : {b, 8'd0};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv4_udp_receive_validator.sv =====
// IPv4/UDP receive validator: header capture, running checksums and final verdict.
// Depends on iuv_pkg for constants, the status type and the ones-complement helpers.
`default_nettype none

// Channel   | Direction | Payload
// s_*       | in        | tdata[7:0] data_byte, tlast final byte of the frame
// m_*       | out       | tdata[2:0] status, tdata[18:3] payload_length, rest zero
// cfg_*     | in        | cfg_wr_data client_port, written when cfg_wr_en is high
//
// One byte per cycle sustained. A byte is registered at the input, then the sums,
// field captures and, on the final byte, the verdict are formed combinationally and
// land in the output register. Reset clears the frame state and sets client_port to
// 68. A stalled output only holds back a final byte; ordinary bytes keep flowing
// while a verdict waits.
module ipv4_udp_receive_validator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [2:0] status, [18:3] payload_length
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);
	import iuv_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;

	logic [15:0]       client_port_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       hdr_sum_q, udp_sum_q;
	logic [7:0]        ver_ihl_q, proto_q;
	logic [15:0]       tlen_q, dport_q, ulen_q, uchk_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [15:0]       plen_q;

	logic              advance, out_free;

	logic [CNT_W-1:0]  cnt_nx;
	logic [15:0]       hdr_sum_nx, udp_sum_nx;
	logic [7:0]        ver_ihl_nx, proto_nx;
	logic [15:0]       tlen_nx, dport_nx, ulen_nx, uchk_nx;
	logic [15:0]       word, udp_fin;
	logic              used, odd;
	status_t           status_d;
	logic [15:0]       plen_d;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_port_q <= CLIENT_PORT_RESET;
		end else if (cfg_wr_en) begin
			client_port_q <= cfg_wr_data;
		end
	end

	// Frame state update for the byte in the input register.
	always_comb begin
		cnt_nx     = cnt_q;
		hdr_sum_nx = hdr_sum_q;
		udp_sum_nx = udp_sum_q;
		ver_ihl_nx = ver_ihl_q;
		proto_nx   = proto_q;
		tlen_nx    = tlen_q;
		dport_nx   = dport_q;
		ulen_nx    = ulen_q;
		uchk_nx    = uchk_q;
		odd        = cnt_q[0];
		word       = odd ? {8'd0, byte_s1} : {byte_s1, 8'd0};
		used       = 1'b0;
		if (cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
			cnt_nx = cnt_q + CNT_W'(1);
			used   = (cnt_q < POS_ALWAYS) || (32'(cnt_q) < 32'(tlen_q));
		end
		if (used) begin
			if (cnt_q < POS_IP_END) begin
				hdr_sum_nx = ones_add(hdr_sum_q, word);
			end
			if (cnt_q >= POS_PSEUDO) begin
				udp_sum_nx = ones_add(udp_sum_q, word);
			end
			case (cnt_q)
				POS_VER_IHL: ver_ihl_nx = byte_s1;
				POS_TLEN_HI, POS_TLEN_LO: tlen_nx = put_half(tlen_q, odd, byte_s1);
				POS_PROTO: proto_nx = byte_s1;
				POS_DPORT_HI, POS_DPORT_LO: dport_nx = put_half(dport_q, odd, byte_s1);
				POS_ULEN_HI, POS_ULEN_LO: ulen_nx = put_half(ulen_q, odd, byte_s1);
				POS_UCHK_HI, POS_UCHK_LO: uchk_nx = put_half(uchk_q, odd, byte_s1);
				default: ;
			endcase
		end
	end

	// Verdict on the frame state including the final byte; first failing check wins.
	always_comb begin
		udp_fin  = ones_add(ones_add(udp_sum_nx, {8'd0, proto_nx}), ulen_nx);
		plen_d   = 16'd0;
		if (proto_nx != PROTO_UDP) begin
			status_d = ST_NOT_UDP;
		end else if (ver_ihl_nx[7:4] != IP_VERSION_4) begin
			status_d = ST_BAD_VER;
		end else if (ver_ihl_nx[3:0] != IHL_NO_OPTIONS) begin
			status_d = ST_BAD_IHL;
		end else if (hdr_sum_nx != SUM_VALID) begin
			status_d = ST_BAD_IPSUM;
		end else if (dport_nx != client_port_q) begin
			status_d = ST_BAD_PORT;
		end else if (tlen_nx < IP_UDP_HDR_BYTES || ulen_nx != tlen_nx - IP_HDR_BYTES) begin
			status_d = ST_BAD_ULEN;
		end else if (uchk_nx != 16'd0 && udp_fin != SUM_VALID) begin
			status_d = ST_BAD_USUM;
		end else begin
			status_d = ST_ACCEPT;
			plen_d   = tlen_nx - IP_UDP_HDR_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			hdr_sum_q <= '0;
			udp_sum_q <= '0;
			ver_ihl_q <= '0;
			proto_q   <= '0;
			tlen_q    <= '0;
			dport_q   <= '0;
			ulen_q    <= '0;
			uchk_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				cnt_q     <= '0;
				hdr_sum_q <= '0;
				udp_sum_q <= '0;
				ver_ihl_q <= '0;
				proto_q   <= '0;
				tlen_q    <= '0;
				dport_q   <= '0;
				ulen_q    <= '0;
				uchk_q    <= '0;
			end else begin
				cnt_q     <= cnt_nx;
				hdr_sum_q <= hdr_sum_nx;
				udp_sum_q <= udp_sum_nx;
				ver_ihl_q <= ver_ihl_nx;
				proto_q   <= proto_nx;
				tlen_q    <= tlen_nx;
				dport_q   <= dport_nx;
				ulen_q    <= ulen_nx;
				uchk_q    <= uchk_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_d;
			plen_q   <= plen_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, plen_q, status_q};

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the IPv4/UDP receive validator: it streams datagrams byte by byte and
// predicts each verdict with its own checksum and header model. It needs rtl/iuv_pkg.sv
// and rtl/ipv4_udp_receive_validator.sv.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import iuv_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       is_last;
	} rx_byte_t;

	typedef struct packed {
		status_t     st;
		logic [15:0] plen;
	} verdict_t;

	// Ways a generated datagram departs from a well-formed one.
	typedef enum int {
		FL_NONE, FL_ZERO_UCHK, FL_BIG_TLEN, FL_NOT_UDP, FL_BAD_VER, FL_BAD_IHL,
		FL_BAD_IPSUM, FL_BAD_PORT, FL_BAD_ULEN, FL_BAD_USUM, FL_SHORT_TLEN,
		FL_TRUNCATE, FL_EXTRA, FL_NOISE
	} flaw_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata     = 8'd0;   // [7:0] data_byte
	logic        s_tlast     = 1'b0;
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [23:0] m_tdata;              // [2:0] status, [18:3] payload_length
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;

	rx_byte_t    byte_q[$];
	verdict_t    verdict_q[$];
	rx_byte_t    nb;
	verdict_t    want;
	int          bytes_queued   = 0;
	int          bytes_taken    = 0;
	int          mismatch_count = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	logic [15:0] port_setting   = CLIENT_PORT_RESET;

	// Predictor state for the frame in progress.
	logic [15:0] pr_count   = '0;
	logic [15:0] pr_hdr_sum = '0;
	logic [15:0] pr_seg_sum = '0;
	logic [15:0] pr_tot_len = '0;
	logic [15:0] pr_dport   = '0;
	logic [15:0] pr_ulen    = '0;
	logic [15:0] pr_uchk    = '0;
	logic [7:0]  pr_ver_ihl = '0;
	logic [7:0]  pr_proto   = '0;

	ipv4_udp_receive_validator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// Folds one accepted byte into the frame model; on the final byte it queues the verdict.
	task automatic predict_byte(input logic [7:0] b, input logic is_last);
		logic [15:0] pos;
		logic [15:0] w;
		logic [15:0] s;
		verdict_t    v;
		if (pr_count < 16'(MAX_FRAME_BYTES)) begin
			pos = pr_count;
			pr_count = pr_count + 16'd1;
			if (pos < 16'd4 || pos < pr_tot_len) begin
				w = pos[0] ? {8'd0, b} : {b, 8'd0};
				if (pos < 16'(POS_IP_END))
					pr_hdr_sum = ones_sum16(pr_hdr_sum, w);
				if (pos >= 16'(POS_PSEUDO))
					pr_seg_sum = ones_sum16(pr_seg_sum, w);
				// The position stays below the frame limit here, so its low bits name it.
				case (pos[CNT_W-1:0])
					POS_VER_IHL:  pr_ver_ihl = b;
					POS_TLEN_HI:  pr_tot_len = {b, 8'd0};
					POS_TLEN_LO:  pr_tot_len[7:0] = b;
					POS_PROTO:    pr_proto = b;
					POS_DPORT_HI: pr_dport = {b, 8'd0};
					POS_DPORT_LO: pr_dport[7:0] = b;
					POS_ULEN_HI:  pr_ulen = {b, 8'd0};
					POS_ULEN_LO:  pr_ulen[7:0] = b;
					POS_UCHK_HI:  pr_uchk = {b, 8'd0};
					POS_UCHK_LO:  pr_uchk[7:0] = b;
					default: ;
				endcase
			end
		end
		if (is_last) begin
			v.plen = 16'd0;
			if (pr_proto != PROTO_UDP)
				v.st = ST_NOT_UDP;
			else if (pr_ver_ihl[7:4] != IP_VERSION_4)
				v.st = ST_BAD_VER;
			else if (pr_ver_ihl[3:0] != IHL_NO_OPTIONS)
				v.st = ST_BAD_IHL;
			else if (pr_hdr_sum != SUM_VALID)
				v.st = ST_BAD_IPSUM;
			else if (pr_dport != port_setting)
				v.st = ST_BAD_PORT;
			else if (pr_tot_len < IP_UDP_HDR_BYTES || pr_ulen != pr_tot_len - IP_HDR_BYTES)
				v.st = ST_BAD_ULEN;
			else begin
				s = ones_sum16(ones_sum16(pr_seg_sum, {8'd0, pr_proto}), pr_ulen);
				if (pr_uchk != 16'd0 && s != SUM_VALID)
					v.st = ST_BAD_USUM;
				else begin
					v.st = ST_ACCEPT;
					v.plen = pr_tot_len - IP_UDP_HDR_BYTES;
				end
			end
			verdict_q.push_back(v);
			pr_count   = '0;
			pr_hdr_sum = '0;
			pr_seg_sum = '0;
			pr_tot_len = '0;
			pr_dport   = '0;
			pr_ulen    = '0;
			pr_uchk    = '0;
			pr_ver_ihl = '0;
			pr_proto   = '0;
		end
	endtask

	// Sender side: presents the pending bytes, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nb = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nb.b;
					s_tlast  <= nb.is_last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver side: stalls at random and checks each verdict against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected verdict, expected none, actual tdata %h",
						$time, m_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[2:0] !== want.st) begin
						mismatch_count++;
						$display("%0t: status expected %0d, actual %0d",
							$time, want.st, m_tdata[2:0]);
					end
					if (m_tdata[18:3] !== want.plen) begin
						mismatch_count++;
						$display("%0t: payload_length expected %0d, actual %0d",
							$time, want.plen, m_tdata[18:3]);
					end
					if (m_tdata[23:19] !== 5'd0) begin
						mismatch_count++;
						$display("%0t: tdata padding expected 0, actual %h",
							$time, m_tdata[23:19]);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic is_last);
		byte_q.push_back('{b: b, is_last: is_last});
		bytes_queued++;
	endtask

	// Builds one datagram with valid sums over what the block will see, then applies a flaw.
	task automatic queue_frame(input flaw_t flaw, input int pay_len);
		logic [7:0]  f[$];
		int          tl, n, stop, i;
		logic [15:0] tl16, ulen, dport, s;
		logic [7:0]  verihl, proto;
		tl     = 28 + pay_len;
		verihl = {IP_VERSION_4, IHL_NO_OPTIONS};
		proto  = PROTO_UDP;
		dport  = port_setting;
		case (flaw)
			FL_NOT_UDP:    proto = PROTO_UDP ^ 8'($urandom_range(1, 255));
			FL_BAD_VER:    verihl[7:4] = IP_VERSION_4 ^ 4'($urandom_range(1, 15));
			FL_BAD_IHL:    verihl[3:0] = IHL_NO_OPTIONS ^ 4'($urandom_range(1, 15));
			FL_BAD_PORT:   dport = port_setting ^ 16'($urandom_range(1, 65535));
			FL_SHORT_TLEN: tl = $urandom_range(0, 27);
			FL_BIG_TLEN:   tl = $urandom_range(MAX_FRAME_BYTES + 1, 65535);
			default: ;
		endcase
		tl16 = 16'(tl);
		ulen = tl16 - IP_HDR_BYTES;
		if (flaw == FL_BAD_ULEN)
			ulen = ulen ^ 16'($urandom_range(1, 65535));
		n = (tl < 28 || tl > MAX_FRAME_BYTES) ? 28 + pay_len : tl;
		for (i = 0; i < n; i++)
			f.push_back(8'($urandom));
		f[0]  = verihl;
		f[2]  = tl16[15:8];
		f[3]  = tl16[7:0];
		f[9]  = proto;
		f[10] = 8'd0;
		f[11] = 8'd0;
		f[22] = dport[15:8];
		f[23] = dport[7:0];
		f[24] = ulen[15:8];
		f[25] = ulen[7:0];
		f[26] = 8'd0;
		f[27] = 8'd0;
		s = '0;
		for (i = 0; i < 20; i++)
			s = ones_sum16(s, i[0] ? {8'd0, f[i]} : {f[i], 8'd0});
		s = ~s;
		if (flaw == FL_BAD_IPSUM)
			s = s ^ 16'($urandom_range(1, 65535));
		f[10] = s[15:8];
		f[11] = s[7:0];
		// The segment sum only covers the bytes that the block will actually take in.
		stop = n;
		if (tl < stop)
			stop = tl;
		if (MAX_FRAME_BYTES < stop)
			stop = MAX_FRAME_BYTES;
		s = '0;
		for (i = 12; i < stop; i++)
			s = ones_sum16(s, i[0] ? {8'd0, f[i]} : {f[i], 8'd0});
		s = ~ones_sum16(ones_sum16(s, {8'd0, proto}), ulen);
		if (flaw == FL_ZERO_UCHK)
			s = 16'd0;
		else if (flaw == FL_BAD_USUM)
			s = s ^ 16'($urandom_range(1, 65535));
		f[26] = s[15:8];
		f[27] = s[7:0];
		case (flaw)
			FL_TRUNCATE: begin
				stop = $urandom_range(1, n - 1);
				while (f.size() > stop)
					f.pop_back();
			end
			FL_EXTRA: begin
				for (i = $urandom_range(1, 6); i > 0; i--)
					f.push_back(8'($urandom));
			end
			FL_NOISE: begin
				f.delete();
				for (i = $urandom_range(1, 40); i > 0; i--)
					f.push_back(8'($urandom));
				if (f.size() > 9 && $urandom_range(0, 1) == 1)
					f[9] = PROTO_UDP;
			end
			default: ;
		endcase
		for (i = 0; i < f.size(); i++)
			push_byte(f[i], i == f.size() - 1);
	endtask

	task automatic queue_random_frame();
		int    r;
		int    pay_len;
		flaw_t flaw;
		r = $urandom_range(0, 99);
		if (r < 45)
			flaw = FL_NONE;
		else if (r < 55)
			flaw = FL_ZERO_UCHK;
		else if (r < 60)
			flaw = FL_BIG_TLEN;
		else
			flaw = flaw_t'($urandom_range(FL_NOT_UDP, FL_NOISE));
		pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
		queue_frame(flaw, pay_len);
	endtask

	// Waits until every byte is taken and every verdict has come back, then idles on further clock edges.
	task automatic drain();
		while (bytes_taken != bytes_queued || verdict_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		port_setting = v;
	endtask

	initial begin : stimulus
		int          ph, k;
		logic [15:0] port_plan [4];
		port_plan[0] = CLIENT_PORT_RESET;
		port_plan[1] = 16'hffff;
		port_plan[2] = 16'h0000;
		port_plan[3] = 16'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			// The receiver idles more first, then the sender, then neither side idles.
			send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 53 : 0;
			recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 34 : 0;
			if (ph != 0)
				write_port(port_plan[ph]);
			if (ph == 0) begin
				push_byte(8'hff, 1'b1);
				for (k = 0; k < 4; k++)
					push_byte(8'h00, k == 3);
				for (k = 0; k < 30; k++)
					push_byte(8'hff, k == 29);
				queue_frame(FL_NONE, 0);
				queue_frame(FL_NONE, 1);
				for (k = FL_ZERO_UCHK; k <= FL_NOISE; k++)
					queue_frame(flaw_t'(k), 4);
			end
			for (k = 0; k < 4; k++)
				queue_random_frame();
			drain();
		end
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
